/* hdl/blfr_pkg.sv */
package blfr_pkg;

	// Default sizing of the line store.
	localparam int MAX_FRAGMENTS_DEF = 64;
	localparam int WIDTH_BITS_DEF    = 24;

	// Fixed field widths of the stream items.
	localparam int LEVEL_W      = 7;
	localparam int FRAG_WIDTH_W = 24;
	localparam int SRC_W        = 6;
	localparam int OFFSET_W     = 30;

	// Packed stream data widths, rounded up to whole bytes.
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;

	localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

endpackage

/* hdl/bidi_line_fragment_reorder_top.sv */
// Channel   Direction  Handshake          Payload
// s_*       input      s_tvalid/s_tready  s_tdata = frag_level, frag_width; s_tlast = line_end
// m_*       output     m_tvalid/m_tready  m_tdata = source_index, x_offset;
//                                         m_tlast = last_result; m_tuser = overflowed
//
// Loading takes one cycle per fragment. After the item that carries s_tlast, s_tready stays
// low through a setup state, one reorder pass per level from the highest down to the lowest
// odd level, and emitting, which output stalls can hold. Memories are not reset. A pass reads
// the visual order memory through a registered port: read and check states per fragment
// scanned, the fragment that ends a run scanned twice, a swap read to close each run, and for
// each swapped pair one read of both, then two writes through the single write port.
module bidi_line_fragment_reorder_top #(
	parameter int MAX_FRAGMENTS = blfr_pkg::MAX_FRAGMENTS_DEF,
	parameter int WIDTH_BITS    = blfr_pkg::WIDTH_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [6:0] frag_level, [30:7] frag_width, [31] zero
	input  logic [blfr_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [5:0] source_index, [35:6] x_offset, [39:36] zero
	output logic [blfr_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                               m_tlast,
	// [0] overflowed
	output logic                               m_tuser
);

	localparam int LEVEL_W  = blfr_pkg::LEVEL_W;
	localparam int OFFSET_W = blfr_pkg::OFFSET_W;
	localparam int SRC_W    = blfr_pkg::SRC_W;
	localparam int IDX_W    = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
	localparam int CNT_W    = $clog2(MAX_FRAGMENTS + 1);
	// Only the low bits of the width field are kept, never more than the field has.
	localparam int W_W      = (WIDTH_BITS < blfr_pkg::FRAG_WIDTH_W) ?
	                          WIDTH_BITS : blfr_pkg::FRAG_WIDTH_W;
	localparam int EXT_W    = (IDX_W > SRC_W) ? IDX_W : SRC_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAGMENTS);

	// Each visual position holds the fragment's level and its logical index, so a
	// reversal moves both together and a scan needs no second lookup.
	typedef struct packed {
		logic [LEVEL_W-1:0] lvl;
		logic [IDX_W-1:0]   src;
	} vis_entry_t;

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_PREP     = 13'b0000000000010,
		S_FIND_RD  = 13'b0000000000100,
		S_FIND_CHK = 13'b0000000001000,
		S_RUN_RD   = 13'b0000000010000,
		S_RUN_CHK  = 13'b0000000100000,
		S_SWAP_RD  = 13'b0000001000000,
		S_SWAP_WA  = 13'b0000010000000,
		S_SWAP_WB  = 13'b0000100000000,
		S_NEXT_LVL = 13'b0001000000000,
		S_EMIT_RD  = 13'b0010000000000,
		S_EMIT_W   = 13'b0100000000000,
		S_EMIT_ADD = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Per-line summary registers.
	logic [CNT_W-1:0]   count_q;
	logic [LEVEL_W-1:0] high_q;
	logic [LEVEL_W-1:0] lowodd_q;
	logic               odd_q;
	logic               drop_q;

	// Sequencer registers.
	logic [LEVEL_W-1:0]  cur_q;
	logic [CNT_W-1:0]    pos_q;
	logic [IDX_W-1:0]    start_q;
	logic [IDX_W-1:0]    lo_q;
	logic [IDX_W-1:0]    hi_q;
	logic [IDX_W-1:0]    k_q;
	logic [OFFSET_W-1:0] off_q;

	// Output register.
	logic                out_valid_q;
	logic [SRC_W-1:0]    out_src_q;
	logic [OFFSET_W-1:0] out_off_q;
	logic                out_last_q;
	logic                out_ovf_q;

	// Memories and their registered read data.
	vis_entry_t     vis_mem [MAX_FRAGMENTS];
	logic [W_W-1:0] wid_mem [MAX_FRAGMENTS];
	vis_entry_t     vis_rd_a;
	vis_entry_t     vis_rd_b;
	logic [W_W-1:0] wid_rd;

	logic               in_acc;
	logic [LEVEL_W-1:0] in_level;
	logic [W_W-1:0]     in_width;
	logic               out_free;

	logic               vis_we;
	logic [IDX_W-1:0]   vis_wa;
	vis_entry_t         vis_wd;
	logic               rd_a_en;
	logic [IDX_W-1:0]   rd_a_addr;
	logic               rd_b_en;
	logic               wid_re;

	logic [OFFSET_W:0]  off_sum;
	logic [EXT_W-1:0]   src_ext;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_level = s_tdata[LEVEL_W-1:0];
	assign in_width = s_tdata[LEVEL_W +: W_W];
	assign out_free = !out_valid_q || m_tready;

	assign off_sum = {1'b0, off_q} + (OFFSET_W + 1)'(wid_rd);
	assign src_ext = EXT_W'(vis_rd_a.src);

	// Memory port control.
	always_comb begin
		vis_we    = 1'b0;
		vis_wa    = count_q[IDX_W-1:0];
		vis_wd    = '{lvl: in_level, src: count_q[IDX_W-1:0]};
		rd_a_en   = 1'b0;
		rd_a_addr = pos_q[IDX_W-1:0];
		rd_b_en   = 1'b0;
		wid_re    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				vis_we = in_acc && (count_q < CNT_MAX);
			end
			S_FIND_RD, S_RUN_RD: begin
				rd_a_en = (pos_q < count_q);
			end
			S_SWAP_RD: begin
				rd_a_en   = (lo_q < hi_q);
				rd_b_en   = (lo_q < hi_q);
				rd_a_addr = lo_q;
			end
			S_SWAP_WA: begin
				vis_we = 1'b1;
				vis_wa = lo_q;
				vis_wd = vis_rd_b;
			end
			S_SWAP_WB: begin
				vis_we = 1'b1;
				vis_wa = hi_q;
				vis_wd = vis_rd_a;
			end
			S_EMIT_RD: begin
				rd_a_en   = 1'b1;
				rd_a_addr = k_q;
			end
			S_EMIT_W: begin
				wid_re = out_free;
			end
			S_PREP, S_FIND_CHK, S_RUN_CHK, S_NEXT_LVL, S_EMIT_ADD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_wa] <= vis_wd;
		end
		if (rd_a_en) begin
			vis_rd_a <= vis_mem[rd_a_addr];
		end
		if (rd_b_en) begin
			vis_rd_b <= vis_mem[hi_q];
		end
	end

	always_ff @(posedge clk) begin
		if (vis_we && (state_q == S_IDLE)) begin
			wid_mem[count_q[IDX_W-1:0]] <= in_width;
		end
		if (wid_re) begin
			wid_rd <= wid_mem[vis_rd_a.src];
		end
	end

	// Sequencer: load, reorder passes, emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			high_q      <= '0;
			lowodd_q    <= '0;
			odd_q       <= 1'b0;
			drop_q      <= 1'b0;
			cur_q       <= '0;
			pos_q       <= '0;
			start_q     <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			k_q         <= '0;
			off_q       <= '0;
			out_valid_q <= 1'b0;
			out_src_q   <= '0;
			out_off_q   <= '0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			// A new result may replace the one being taken in the same cycle.
			if ((state_q == S_EMIT_W) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (count_q < CNT_MAX) begin
							count_q <= count_q + 1'b1;
							if (in_level > high_q) begin
								high_q <= in_level;
							end
							if (in_level[0] && (!odd_q || (in_level < lowodd_q))) begin
								lowodd_q <= in_level;
								odd_q    <= 1'b1;
							end
						end else begin
							drop_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					cur_q <= high_q;
					pos_q <= '0;
					k_q   <= '0;
					off_q <= '0;
					// A line without an odd level keeps its logical order.
					state_q <= odd_q ? S_FIND_RD : S_EMIT_RD;
				end
				S_FIND_RD: begin
					state_q <= (pos_q < count_q) ? S_FIND_CHK : S_NEXT_LVL;
				end
				S_FIND_CHK: begin
					pos_q <= pos_q + 1'b1;
					if (vis_rd_a.lvl >= cur_q) begin
						start_q <= pos_q[IDX_W-1:0];
						state_q <= S_RUN_RD;
					end else begin
						state_q <= S_FIND_RD;
					end
				end
				S_RUN_RD: begin
					if (pos_q < count_q) begin
						state_q <= S_RUN_CHK;
					end else begin
						lo_q    <= start_q;
						hi_q    <= IDX_W'(pos_q - 1'b1);
						state_q <= S_SWAP_RD;
					end
				end
				S_RUN_CHK: begin
					if (vis_rd_a.lvl >= cur_q) begin
						pos_q   <= pos_q + 1'b1;
						state_q <= S_RUN_RD;
					end else begin
						lo_q    <= start_q;
						hi_q    <= IDX_W'(pos_q - 1'b1);
						state_q <= S_SWAP_RD;
					end
				end
				S_SWAP_RD: begin
					// The scan resumes at the first position after the run.
					state_q <= (lo_q < hi_q) ? S_SWAP_WA : S_FIND_RD;
				end
				S_SWAP_WA: begin
					state_q <= S_SWAP_WB;
				end
				S_SWAP_WB: begin
					lo_q    <= lo_q + 1'b1;
					hi_q    <= hi_q - 1'b1;
					state_q <= S_SWAP_RD;
				end
				S_NEXT_LVL: begin
					if (cur_q <= lowodd_q) begin
						state_q <= S_EMIT_RD;
					end else begin
						cur_q   <= cur_q - 1'b1;
						pos_q   <= '0;
						state_q <= S_FIND_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_W;
				end
				S_EMIT_W: begin
					if (out_free) begin
						out_src_q   <= src_ext[SRC_W-1:0];
						out_off_q   <= off_q;
						out_last_q  <= ((CNT_W'(k_q) + 1'b1) == count_q);
						out_ovf_q   <= drop_q;
						state_q     <= S_EMIT_ADD;
					end
				end
				S_EMIT_ADD: begin
					// The running offset saturates instead of wrapping.
					off_q <= off_sum[OFFSET_W] ? blfr_pkg::OFFSET_MAX : off_sum[OFFSET_W-1:0];
					k_q   <= k_q + 1'b1;
					if ((CNT_W'(k_q) + 1'b1) == count_q) begin
						count_q  <= '0;
						high_q   <= '0;
						lowodd_q <= '0;
						odd_q    <= 1'b0;
						drop_q   <= 1'b0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_EMIT_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(blfr_pkg::OUT_TDATA_W - SRC_W - OFFSET_W)'(0), out_off_q, out_src_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("fragment count beyond capacity");

	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWAP_WA || state_q == S_SWAP_WB) |-> (lo_q < hi_q))
		else $error("swap issued with crossed pointers");

	a_odd_summary: assert property (@(posedge clk) disable iff (!arst_n)
		odd_q |-> (lowodd_q[0] && (lowodd_q <= high_q)))
		else $error("lowest odd level inconsistent with highest level");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_W) |-> (CNT_W'(k_q) < count_q))
		else $error("emit index beyond stored fragments");
`endif

endmodule

/* tb/tb.sv */
module tb;
	// Fragments go in on the slave stream, one item per fragment, with s_tlast
	// on the one that closes the line. A line model works out the visual order
	// on every accepted closing item and queues the placements that the master
	// stream must produce. A short directed table comes first, random lines
	// follow, and the receiver twice holds off long enough to stall the input.

	localparam int CAPACITY     = blfr_pkg::MAX_FRAGMENTS_DEF;
	localparam int LEVEL_W      = blfr_pkg::LEVEL_W;
	localparam int FRAG_WIDTH_W = blfr_pkg::FRAG_WIDTH_W;
	localparam int SRC_W        = blfr_pkg::SRC_W;
	localparam int OFFSET_W     = blfr_pkg::OFFSET_W;
	localparam int IN_TDATA_W   = blfr_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W  = blfr_pkg::OUT_TDATA_W;
	localparam int TARGET_ITEMS = 430;
	localparam int HOLD_CYCLES  = 500;
	localparam int DRAIN_CYCLES = 300;
	localparam int N_DIRECTED   = 23;

	// One output item: where a fragment lands on the line.
	typedef struct packed {
		logic [SRC_W-1:0]    src;
		logic [OFFSET_W-1:0] off;
		logic                last;
		logic                ovf;
	} placement_t;

	// One row of the directed table. When typed is set, the row closes a
	// single-fragment line and its one placement is given in want.
	typedef struct packed {
		logic [LEVEL_W-1:0]      lvl;
		logic [FRAG_WIDTH_W-1:0] w;
		logic                    closes;
		logic                    typed;
		placement_t              want;
	} frag_row_t;

	localparam placement_t LONE = '{src: '0, off: '0, last: 1'b1, ovf: 1'b0};
	localparam placement_t NONE = '0;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   m_tuser;

	bidi_line_fragment_reorder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// Hand-picked lines. The first three are single fragments at the level and
	// width extremes, and their one placement can be written down directly.
	// Every other row is checked against the line model.
	frag_row_t directed_rows [N_DIRECTED] = '{
		'{7'd0,   24'h000000, 1'b1, 1'b1, LONE},
		'{7'd127, 24'hFFFFFF, 1'b1, 1'b1, LONE},
		'{7'd126, 24'h800000, 1'b1, 1'b1, LONE},
		// Mixed direction: a right-to-left run around a deeper fragment.
		'{7'd0,   24'h000100, 1'b0, 1'b0, NONE},
		'{7'd1,   24'h000280, 1'b0, 1'b0, NONE},
		'{7'd2,   24'h000040, 1'b0, 1'b0, NONE},
		'{7'd1,   24'h001000, 1'b0, 1'b0, NONE},
		'{7'd0,   24'h000001, 1'b1, 1'b0, NONE},
		// Only even levels, so logical order is kept.
		'{7'd2,   24'h000A00, 1'b0, 1'b0, NONE},
		'{7'd4,   24'h000300, 1'b0, 1'b0, NONE},
		'{7'd2,   24'h7FFFFF, 1'b1, 1'b0, NONE},
		// Fully right-to-left: the whole line turns around.
		'{7'd1,   24'h000100, 1'b0, 1'b0, NONE},
		'{7'd1,   24'h000200, 1'b0, 1'b0, NONE},
		'{7'd1,   24'h000300, 1'b0, 1'b0, NONE},
		'{7'd1,   24'h000400, 1'b1, 1'b0, NONE},
		// Nested levels climbing by two.
		'{7'd1,   24'h010000, 1'b0, 1'b0, NONE},
		'{7'd3,   24'h020000, 1'b0, 1'b0, NONE},
		'{7'd5,   24'h030000, 1'b0, 1'b0, NONE},
		'{7'd7,   24'h040000, 1'b1, 1'b0, NONE},
		// Alternating bit patterns in both fields.
		'{7'h55,  24'h555555, 1'b0, 1'b0, NONE},
		'{7'h2A,  24'hAAAAAA, 1'b1, 1'b0, NONE},
		// High even level next to a high odd level.
		'{7'd64,  24'hFFFFFF, 1'b0, 1'b0, NONE},
		'{7'd63,  24'hFFFFFF, 1'b1, 1'b0, NONE}
	};

	// Line model state.
	logic [LEVEL_W-1:0]      lvl_mem   [CAPACITY];
	logic [FRAG_WIDTH_W-1:0] width_mem [CAPACITY];
	logic [SRC_W-1:0]        order_mem [CAPACITY];
	int unsigned             frag_cnt;
	logic [LEVEL_W-1:0]      top_lvl;
	logic [LEVEL_W-1:0]      odd_floor;
	bit                      odd_any;
	bit                      lost;

	placement_t line_placements[$];
	placement_t pending_placements[$];

	int unsigned cycle_no;
	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned lines_closed;
	int unsigned overflow_lines;
	int unsigned fails;
	int unsigned hold_left;
	int unsigned holds_done;

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
	end

	// A call asks for a break with a chance of 9 in a hundred: the receiver asks every cycle,
	// the sender after each fragment. In the cycle_no window below neither side idles at all.
	function automatic bit take_break();
		if (cycle_no >= 2000 && cycle_no < 5000) begin
			return 1'b0;
		end
		return $urandom_range(99) < 9;
	endfunction

	// Stores one fragment. When it closes the line, this runs the level-by-level
	// run reversal and fills line_placements with the placements in visual order.
	task automatic place_fragment(input logic [LEVEL_W-1:0] lvl,
			input logic [FRAG_WIDTH_W-1:0] w, input bit closes);
		int unsigned cur;
		int unsigned pos;
		int unsigned stop;
		int unsigned a;
		int unsigned b;
		logic [SRC_W-1:0] t;
		logic [OFFSET_W:0] acc;
		placement_t p;

		line_placements.delete();
		if (frag_cnt < CAPACITY) begin
			lvl_mem[frag_cnt] = lvl;
			width_mem[frag_cnt] = w;
			order_mem[frag_cnt] = frag_cnt[SRC_W-1:0];
			frag_cnt++;
			if (lvl > top_lvl) begin
				top_lvl = lvl;
			end
			if (lvl[0] && (!odd_any || lvl < odd_floor)) begin
				odd_floor = lvl;
				odd_any = 1'b1;
			end
		end else begin
			lost = 1'b1;
		end
		if (!closes) begin
			return;
		end

		// A line with no odd level stays in logical order.
		if (odd_any) begin
			cur = 32'(top_lvl);
			forever begin
				pos = 0;
				while (pos < frag_cnt) begin
					while (pos < frag_cnt && lvl_mem[order_mem[pos]] < cur) begin
						pos++;
					end
					stop = pos;
					while (stop < frag_cnt && lvl_mem[order_mem[stop]] >= cur) begin
						stop++;
					end
					a = pos;
					b = stop;
					while (a + 1 < b) begin
						t = order_mem[a];
						order_mem[a] = order_mem[b-1];
						order_mem[b-1] = t;
						a++;
						b--;
					end
					pos = stop;
				end
				if (cur <= odd_floor) begin
					break;
				end
				cur--;
			end
		end

		// The offset saturates, although 64 fragments of 24-bit width stay
		// just below the ceiling.
		acc = '0;
		for (int unsigned k = 0; k < frag_cnt; k++) begin
			p.src = order_mem[k];
			p.off = acc[OFFSET_W-1:0];
			p.last = (k + 1 == frag_cnt);
			p.ovf = lost;
			line_placements = {line_placements, p};
			acc = acc + (OFFSET_W + 1)'(width_mem[order_mem[k]]);
			if (acc > {1'b0, blfr_pkg::OFFSET_MAX}) begin
				acc = {1'b0, blfr_pkg::OFFSET_MAX};
			end
		end
		lines_closed++;
		if (lost) begin
			overflow_lines++;
		end
		frag_cnt = 0;
		top_lvl = '0;
		odd_floor = '0;
		odd_any = 1'b0;
		lost = 1'b0;
	endtask

	// Offers one fragment, waits for it to be taken, queues what it leads to,
	// and sometimes leaves a gap before the next one.
	task automatic deliver(input logic [LEVEL_W-1:0] lvl,
			input logic [FRAG_WIDTH_W-1:0] w, input bit closes, input bit typed,
			input placement_t want);
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, w, lvl};
		s_tlast <= closes;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		items_sent++;
		place_fragment(lvl, w, closes);
		if (typed) begin
			pending_placements = {pending_placements, want};
		end else begin
			pending_placements = {pending_placements, line_placements};
		end
		if (take_break()) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Sends one random line of len fragments. Levels come from lo..hi. Some
	// fragments take any seven-bit level (wild_pct percent), and even_only
	// clears the direction bit on every level.
	task automatic send_line(input int unsigned len, input int unsigned lo,
			input int unsigned hi, input int unsigned wild_pct, input bit even_only);
		logic [LEVEL_W-1:0] lvl;
		logic [FRAG_WIDTH_W-1:0] w;
		int unsigned pick;

		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(99) < wild_pct) begin
				lvl = LEVEL_W'($urandom_range(0, 127));
			end else begin
				lvl = LEVEL_W'($urandom_range(lo, hi));
			end
			if (even_only) begin
				lvl[0] = 1'b0;
			end
			pick = $urandom_range(9);
			if (pick == 0) begin
				w = '0;
			end else if (pick == 1) begin
				w = '1;
			end else begin
				w = FRAG_WIDTH_W'($urandom());
			end
			deliver(lvl, w, i + 1 == len, 1'b0, NONE);
		end
	endtask

	// Output side: checks each accepted item and decides tready for the next
	// cycle. Twice during the run it holds tready low while hold_left counts down
	// from HOLD_CYCLES, and the sender keeps going.
	initial begin
		placement_t exp_p;
		placement_t got;

		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.src = m_tdata[SRC_W-1:0];
				got.off = m_tdata[SRC_W+OFFSET_W-1:SRC_W];
				got.last = m_tlast;
				got.ovf = m_tuser;
				results_seen++;
				if (pending_placements.size() == 0) begin
					$display("%0t: unexpected item src=%0d off=%0h last=%0b ovf=%0b",
						$time, got.src, got.off, got.last, got.ovf);
					fails++;
				end else begin
					exp_p = pending_placements.pop_front();
					if (got.src !== exp_p.src) begin
						$display("%0t: source_index expected %0d actual %0d",
							$time, exp_p.src, got.src);
						fails++;
					end
					if (got.off !== exp_p.off) begin
						$display("%0t: x_offset expected %0h actual %0h",
							$time, exp_p.off, got.off);
						fails++;
					end
					if (got.last !== exp_p.last) begin
						$display("%0t: last_result expected %0b actual %0b",
							$time, exp_p.last, got.last);
						fails++;
					end
					if (got.ovf !== exp_p.ovf) begin
						$display("%0t: overflowed expected %0b actual %0b",
							$time, exp_p.ovf, got.ovf);
						fails++;
					end
				end
			end
			if (hold_left == 0 && holds_done < 2 && results_seen >= 120 + 200 * holds_done) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !take_break();
			end
		end
	end

	// Overall time limit. The slowest legal run stays far below it, even with
	// lines at level 127 that need over a hundred reversal passes.
	initial begin
		#8000000;
		$display("status: fail");
		$finish;
	end

	// Reset, directed table, random lines, then drain and report.
	initial begin
		int unsigned kind;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cycle_no = 0;
		items_sent = 0;
		results_seen = 0;
		lines_closed = 0;
		overflow_lines = 0;
		fails = 0;
		hold_left = 0;
		holds_done = 0;
		frag_cnt = 0;
		top_lvl = '0;
		odd_floor = '0;
		odd_any = 1'b0;
		lost = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			deliver(directed_rows[i].lvl, directed_rows[i].w, directed_rows[i].closes,
				directed_rows[i].typed, directed_rows[i].want);
		end

		// Mostly short lines with low levels. Now and then a line takes levels
		// over the full range, has no odd level, fills the store exactly, or
		// runs past it so that the tail, the closing fragment included, is dropped.
		while (items_sent < TARGET_ITEMS) begin
			kind = $urandom_range(99);
			if (kind < 66) begin
				send_line($urandom_range(1, 8), 0, 5, 10, 1'b0);
			end else if (kind < 80) begin
				send_line($urandom_range(9, 20), 0, 9, 3, 1'b0);
			end else if (kind < 88) begin
				send_line($urandom_range(1, 10), 0, 8, 0, 1'b1);
			end else if (kind < 94) begin
				send_line(CAPACITY, 0, 3, 0, 1'b0);
			end else begin
				send_line($urandom_range(CAPACITY + 1, CAPACITY + 6), 0, 4, 0, 1'b0);
			end
		end
		s_tvalid <= 1'b0;

		while (pending_placements.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d fragments in %0d lines (%0d with dropped fragments).",
			items_sent, lines_closed, overflow_lines);
		$display("Checked %0d placements, %0d mismatches.", results_seen, fails);
		if (fails == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
